// ===== rtl/clnq_pkg.sv =====
package clnq_pkg;

	localparam int ITERATIONS = 16;

	localparam int XW = 21;
	localparam int ZW = 21;
	localparam int CW = 22;
	localparam int LW = 22;
	localparam int AW = 31;
	localparam int NW = 18;

	localparam logic [16:0] LN2_Q16 = 17'h0B172;
	localparam logic signed [XW-1:0] ONE_Q16 = XW'(32'h0001_0000);

	localparam logic [15:0] ATANH_TAB [16] = '{
		16'h0000,
		16'h8C9F, 16'h4163, 16'h202B, 16'h1005,
		16'h0801, 16'h0400, 16'h0200, 16'h0100,
		16'h0080, 16'h0040, 16'h0020, 16'h0010,
		16'h0008, 16'h0004, 16'h0002
	};

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [CW-1:0] corr;
		logic                 derr;
	} cordic_t;

	// step 4 runs twice
	function automatic logic [3:0] step_shift(input int s);
		if (s < 4) return 4'(s + 1);
		return 4'(s);
	endfunction

endpackage

// ===== rtl/cordic_natural_log_q16.sv =====
// Natural logarithm of a signed Q16.16 argument, result in signed Q6.16 (22 bits).
// Zero or negative arguments give 0 with domain_error set. Fully pipelined: one item
// per cycle while the output is taken at once; 4 normalization stages, one stage per
// hyperbolic CORDIC step with step 4 done twice, 16 steps in all, and one output
// stage. Each stage holds its item under back-pressure, so a stalled output fills
// the pipeline before in_ready drops.
module cordic_natural_log_q16 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [31:0]             argument,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [clnq_pkg::LW-1:0] log_value,
	output logic                           domain_error
);

	clnq_pkg::cordic_t stg [clnq_pkg::ITERATIONS+1];
	logic              vld [clnq_pkg::ITERATIONS+1];
	logic              rdy [clnq_pkg::ITERATIONS+1];

	clnq_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.argument  (argument),
		.out_valid (vld[0]),
		.out_ready (rdy[0]),
		.out_data  (stg[0])
	);

	for (genvar s = 0; s < clnq_pkg::ITERATIONS; s++) begin : g_step
		clnq_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (clnq_pkg::step_shift(s)),
			.in_valid  (vld[s]),
			.in_ready  (rdy[s]),
			.in_data   (stg[s]),
			.out_valid (vld[s+1]),
			.out_ready (rdy[s+1]),
			.out_data  (stg[s+1])
		);
	end

	// output stage: 2z - correction
	logic                           vld_sout;
	logic signed [clnq_pkg::LW-1:0] log_sout;
	logic                           derr_sout;
	logic signed [clnq_pkg::LW-1:0] r;

	assign rdy[clnq_pkg::ITERATIONS] = !vld_sout || out_ready;

	assign r = (clnq_pkg::LW'(stg[clnq_pkg::ITERATIONS].z) <<< 1)
	         - clnq_pkg::LW'(stg[clnq_pkg::ITERATIONS].corr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sout <= 1'b0;
		end else if (rdy[clnq_pkg::ITERATIONS]) begin
			vld_sout <= vld[clnq_pkg::ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		if (vld[clnq_pkg::ITERATIONS] && rdy[clnq_pkg::ITERATIONS]) begin
			derr_sout <= stg[clnq_pkg::ITERATIONS].derr;
			log_sout  <= stg[clnq_pkg::ITERATIONS].derr ? '0 : r;
		end
	end

	assign out_valid    = vld_sout;
	assign log_value    = log_sout;
	assign domain_error = derr_sout;

endmodule

// ===== rtl/clnq_norm.sv =====
module clnq_norm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  argument,
	output logic                out_valid,
	input  logic                out_ready,
	output clnq_pkg::cordic_t   out_data
);

	// stage 1: domain check
	logic                     vld_s1;
	logic [clnq_pkg::AW-1:0]  a_s1;
	logic                     derr_s1;
	// stage 2: per-byte leading one
	logic                     vld_s2;
	logic [clnq_pkg::AW-1:0]  a_s2;
	logic                     derr_s2;
	logic [3:0]               nz_s2;
	logic [3:0][2:0]          pos_s2;
	// stage 3: shift amount and correction
	logic                     vld_s3;
	logic [clnq_pkg::AW-1:0]  a_s3;
	logic                     derr_s3;
	logic                     left_s3;
	logic [3:0]               amt_s3;
	logic signed [clnq_pkg::CW-1:0] corr_s3;
	// stage 4: normalized x, y
	logic                     vld_s4;
	clnq_pkg::cordic_t        d_s4;

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4   = !vld_s4 || out_ready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	// byte-wise leading one search
	logic [31:0]     a_pad;
	logic [3:0]      nz_n;
	logic [3:0][2:0] pos_n;

	always_comb begin
		a_pad = {1'b0, a_s1};
		for (int g = 0; g < 4; g++) begin
			nz_n[g]  = 1'b0;
			pos_n[g] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (a_pad[8*g + b]) begin
					nz_n[g]  = 1'b1;
					pos_n[g] = 3'(b);
				end
			end
		end
	end

	// merge bytes, derive shift
	logic [4:0] msb_n;
	logic       left_n;
	logic [3:0] amt_n;
	logic signed [4:0] k_n;
	logic signed [clnq_pkg::CW-1:0] corr_n;

	always_comb begin
		msb_n = 5'd0;
		for (int g = 0; g < 4; g++) begin
			if (nz_s2[g]) msb_n = {2'(g), pos_s2[g]};
		end
		left_n = 1'b0;
		amt_n  = 4'd0;
		if (msb_n < 5'd15) begin
			left_n = 1'b1;
			amt_n  = 4'(5'd15 - msb_n);
		end else if (msb_n > 5'd16) begin
			amt_n  = 4'(msb_n - 5'd16);
		end
		k_n    = left_n ? $signed({1'b0, amt_n}) : -$signed({1'b0, amt_n});
		corr_n = clnq_pkg::CW'(clnq_pkg::CW'(k_n) * $signed(clnq_pkg::CW'(clnq_pkg::LN2_Q16)));
	end

	// barrel shift into [0.5, 2)
	logic [clnq_pkg::NW-1:0] an_n;

	always_comb begin
		if (left_s3) an_n = clnq_pkg::NW'(a_s3 << amt_s3);
		else         an_n = clnq_pkg::NW'(a_s3 >> amt_s3);
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			a_s1    <= argument[clnq_pkg::AW-1:0];
			derr_s1 <= argument[31] || (argument == 32'sd0);
		end
		if (vld_s1 && rdy_s2) begin
			a_s2    <= a_s1;
			derr_s2 <= derr_s1;
			nz_s2   <= nz_n;
			pos_s2  <= pos_n;
		end
		if (vld_s2 && rdy_s3) begin
			a_s3    <= a_s2;
			derr_s3 <= derr_s2;
			left_s3 <= left_n;
			amt_s3  <= amt_n;
			corr_s3 <= corr_n;
		end
		if (vld_s3 && rdy_s4) begin
			d_s4.x    <= $signed(clnq_pkg::XW'(an_n)) + clnq_pkg::ONE_Q16;
			d_s4.y    <= $signed(clnq_pkg::XW'(an_n)) - clnq_pkg::ONE_Q16;
			d_s4.z    <= '0;
			d_s4.corr <= corr_s3;
			d_s4.derr <= derr_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_data  = d_s4;

endmodule

// ===== rtl/clnq_step.sv =====
module clnq_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [3:0]        shift,
	input  logic              in_valid,
	output logic              in_ready,
	input  clnq_pkg::cordic_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output clnq_pkg::cordic_t out_data
);

	logic              vld_s1;
	clnq_pkg::cordic_t d_s1;

	logic signed [clnq_pkg::XW-1:0] dx, dy;
	logic signed [clnq_pkg::ZW-1:0] t;

	assign in_ready = !vld_s1 || out_ready;

	assign dx = in_data.x >>> shift;
	assign dy = in_data.y >>> shift;
	assign t  = $signed(clnq_pkg::ZW'(clnq_pkg::ATANH_TAB[shift]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			d_s1.corr <= in_data.corr;
			d_s1.derr <= in_data.derr;
			if (in_data.y < 0) begin
				d_s1.x <= in_data.x + dy;
				d_s1.y <= in_data.y + dx;
				d_s1.z <= in_data.z - t;
			end else begin
				d_s1.x <= in_data.x - dy;
				d_s1.y <= in_data.y - dx;
				d_s1.z <= in_data.z + t;
			end
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = d_s1;

endmodule

// ===== rtl/clnq_checker.sv =====
module clnq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic signed [31:0]             argument,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [clnq_pkg::LW-1:0] log_value,
	input logic                           domain_error
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(log_value) && $stable(domain_error))
		else $error("stalled result changed");

	a_derr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && domain_error |-> log_value == '0)
		else $error("domain error with nonzero log");

	// empty output stage means the whole pipe can move
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with output empty");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !domain_error |->
			log_value > -22'sd800000 && log_value < 22'sd800000)
		else $error("log out of range");

endmodule

bind cordic_natural_log_q16 clnq_checker u_clnq_checker (.*);
